@@ sv/gscl_pkg.sv @@
package gscl_pkg;

  localparam int NUM_STOPS = 8;
  localparam int IDX_W     = 3;
  localparam int POS_W     = 17;
  localparam int CHAN_W    = 8;
  localparam int NUM_CHAN  = 4;
  localparam int STOP_W    = 50;
  localparam int PROD_W    = POS_W + CHAN_W;
  localparam int NUM_W     = PROD_W + 2;
  localparam int DEN_W     = POS_W + 1;

  // Stop register fields.
  localparam int STOP_VALID_BIT = 49;
  localparam int STOP_POS_LSB   = 32;

  localparam logic [STOP_W-1:0] STOP0_RESET = 50'd562950056066148;
  localparam logic [STOP_W-1:0] STOP1_RESET = 50'd844425184432308;

  typedef enum logic [1:0] {
    KIND_INVALID,
    KIND_SOLID,
    KIND_LERP
  } kind_t;

  // Candidate stop during the nearest-stop search.
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
    logic [IDX_W-1:0] idx;
  } cand_t;

  // Data that rides alongside the divider.
  typedef struct packed {
    logic [NUM_CHAN-1:0][CHAN_W-1:0] c0;
    logic [NUM_CHAN-1:0]             neg;
    logic                            cvalid;
  } side_t;

  // Nearest lower candidate; a holds the lower indices and wins ties.
  function automatic cand_t pick_lower(input cand_t a, input cand_t b);
    cand_t r;
    r = (b.found && (!a.found || b.pos > a.pos)) ? b : a;
    return r;
  endfunction

  // Nearest upper candidate; a holds the lower indices and wins ties.
  function automatic cand_t pick_upper(input cand_t a, input cand_t b);
    cand_t r;
    r = (b.found && (!a.found || b.pos < a.pos)) ? b : a;
    return r;
  endfunction

endpackage

@@ sv/gscl_div.sv @@
// Pipelined restoring divider for four channels, one quotient bit per stage.
module gscl_div (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      en,
  input  logic                                      in_valid,
  input  logic [gscl_pkg::NUM_CHAN-1:0][gscl_pkg::NUM_W-1:0] num,
  input  logic [gscl_pkg::DEN_W-1:0]                den,
  input  gscl_pkg::side_t                           in_side,
  output logic                                      out_valid,
  output logic [gscl_pkg::NUM_CHAN-1:0][gscl_pkg::CHAN_W-1:0] quot,
  output gscl_pkg::side_t                           out_side
);
  import gscl_pkg::*;

  localparam int NSTG = CHAN_W;

  logic [NSTG:0]                              v;
  logic [NSTG:0][NUM_CHAN-1:0][NUM_W-1:0]     rem;
  logic [NSTG:0][NUM_CHAN-1:0][CHAN_W-1:0]    q;
  logic [NSTG:0][DEN_W-1:0]                   den_s;
  side_t [NSTG:0]                             side_s;

  // Stage zero is the input.
  assign v[0]      = in_valid;
  assign rem[0]    = num;
  assign q[0]      = '0;
  assign den_s[0]  = den;
  assign side_s[0] = in_side;

  for (genvar b = 0; b < NSTG; b++) begin : g_stage
    logic [NUM_W-1:0]                  shifted;
    logic [NUM_CHAN-1:0]               ge;
    logic [NUM_CHAN-1:0][NUM_W-1:0]    rem_next;

    // Trial subtract of the divisor at this quotient bit weight.
    always_comb begin
      shifted = NUM_W'(den_s[b]) << (NSTG - 1 - b);
      for (int c = 0; c < NUM_CHAN; c++) begin
        ge[c]       = rem[b][c] >= shifted;
        rem_next[c] = ge[c] ? rem[b][c] - shifted : rem[b][c];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[b+1] <= 1'b0;
      end else if (en) begin
        v[b+1] <= v[b];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[b+1]    <= rem_next;
        den_s[b+1]  <= den_s[b];
        side_s[b+1] <= side_s[b];
        for (int c = 0; c < NUM_CHAN; c++) begin
          q[b+1][c] <= {q[b][c][CHAN_W-2:0], ge[c]};
        end
      end
    end
  end

  assign out_valid = v[NSTG];
  assign quot      = q[NSTG];
  assign out_side  = side_s[NSTG];

endmodule

@@ sv/gradient_stop_color_lookup.sv @@
// Linear gradient color ramp. Each transfer on the slave side carries one
// 17-bit position (65536 means 1.0) and produces exactly one RGBA color on
// the master side, with tuser set when a color was found. Up to eight stops
// are written through the configuration port (index 0..7, bit 49 valid,
// bits 48:32 position, bits 31:0 color R,G,B,A from the high byte). The
// pipeline accepts one position per clock unless the master side stalls, and
// is built from one compare stage, one search stage, one setup stage, one
// multiply stage, eight divider stages (one quotient bit each) and the output
// register. A stall on the master side freezes the whole pipeline. Stops
// must be written only while no transfer is in flight; the block does not check.
module gradient_stop_color_lookup (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [23:0]                    s_tdata,   // position[16:0], zero pad
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [31:0]                    m_tdata,   // red, green, blue, alpha from the low byte
  output logic                           m_tuser,   // color_valid
  input  logic                           cfg_we,
  input  logic [gscl_pkg::IDX_W-1:0]     cfg_index,
  input  logic [gscl_pkg::STOP_W-1:0]    cfg_data
);
  import gscl_pkg::*;

  logic en;
  logic [NUM_STOPS-1:0][STOP_W-1:0] stops;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stop registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STOPS; i++) begin
        if (i == 0) stops[i] <= STOP0_RESET;
        else if (i == 1) stops[i] <= STOP1_RESET;
        else stops[i] <= '0;
      end
    end else if (cfg_we) begin
      stops[cfg_index] <= cfg_data;
    end
  end

  function automatic logic [POS_W-1:0] spos(input logic [STOP_W-1:0] s);
    return s[STOP_POS_LSB +: POS_W];
  endfunction

  function automatic logic [CHAN_W-1:0] schan(input logic [STOP_W-1:0] s, input int k);
    return s[(NUM_CHAN - 1 - k) * CHAN_W +: CHAN_W];
  endfunction

  // Stage 1: compare the position with every stop.
  logic                 s1_v;
  logic [POS_W-1:0]     s1_pos;
  logic [NUM_STOPS-1:0] s1_below, s1_above;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pos <= s_tdata[POS_W-1:0];
      for (int i = 0; i < NUM_STOPS; i++) begin
        s1_below[i] <= stops[i][STOP_VALID_BIT] && spos(stops[i]) < s_tdata[POS_W-1:0];
        s1_above[i] <= stops[i][STOP_VALID_BIT] && spos(stops[i]) > s_tdata[POS_W-1:0];
      end
    end
  end

  // Stage 2: tree search for the nearest stops and classification.
  cand_t [NUM_STOPS-1:0] lo_l0, hi_l0;
  cand_t [3:0] lo_l1, hi_l1;
  cand_t [1:0] lo_l2, hi_l2;
  cand_t lo_c, hi_c;
  logic [NUM_STOPS-1:0] vbits;
  logic [IDX_W-1:0] first_idx;
  logic [IDX_W:0] nvalid;
  kind_t kind_next;
  logic [IDX_W-1:0] solid_next;

  always_comb begin
    for (int i = 0; i < NUM_STOPS; i++) begin
      vbits[i] = stops[i][STOP_VALID_BIT];
      lo_l0[i] = '{found: s1_below[i], pos: spos(stops[i]), idx: IDX_W'(i)};
      hi_l0[i] = '{found: s1_above[i], pos: spos(stops[i]), idx: IDX_W'(i)};
    end
    for (int i = 0; i < 4; i++) begin
      lo_l1[i] = pick_lower(lo_l0[2*i], lo_l0[2*i+1]);
      hi_l1[i] = pick_upper(hi_l0[2*i], hi_l0[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      lo_l2[i] = pick_lower(lo_l1[2*i], lo_l1[2*i+1]);
      hi_l2[i] = pick_upper(hi_l1[2*i], hi_l1[2*i+1]);
    end
    lo_c = pick_lower(lo_l2[0], lo_l2[1]);
    hi_c = pick_upper(hi_l2[0], hi_l2[1]);

    nvalid    = ($countones(vbits) > 1) ? (IDX_W+1)'(2) : (IDX_W+1)'($countones(vbits));
    first_idx = '0;
    for (int i = NUM_STOPS - 1; i >= 0; i--) begin
      if (vbits[i]) first_idx = IDX_W'(i);
    end

    kind_next  = KIND_INVALID;
    solid_next = first_idx;
    priority if (nvalid == '0) begin
      kind_next = KIND_INVALID;
    end else if (nvalid == (IDX_W+1)'(1)) begin
      kind_next = KIND_SOLID;
    end else if (lo_c.found && hi_c.found) begin
      kind_next = KIND_LERP;
    end else if (lo_c.found) begin
      kind_next  = KIND_SOLID;
      solid_next = lo_c.idx;
    end else if (hi_c.found) begin
      kind_next  = KIND_SOLID;
      solid_next = hi_c.idx;
    end else begin
      kind_next = KIND_INVALID;
    end
  end

  logic             s2_v;
  kind_t            s2_kind;
  logic [IDX_W-1:0] s2_solid, s2_lo, s2_hi;
  logic [POS_W-1:0] s2_pos;

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= s1_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_kind  <= kind_next;
      s2_solid <= solid_next;
      s2_lo    <= lo_c.idx;
      s2_hi    <= hi_c.idx;
      s2_pos   <= s1_pos;
    end
  end

  // Stage 3: offsets, span and per-channel differences.
  logic                            s3_v;
  side_t                           s3_side, s3_side_next;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] s3_diff, s3_diff_next;
  logic [POS_W-1:0]                s3_off, s3_span;
  logic [POS_W-1:0]                s3_off_next, s3_span_next;

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (en) s3_v <= s2_v;
  end

  always_comb begin
    s3_side_next.cvalid = s2_kind != KIND_INVALID;
    s3_side_next.c0     = '0;
    s3_side_next.neg    = '0;
    s3_diff_next        = '0;
    s3_off_next         = '0;
    s3_span_next        = POS_W'(1);
    unique case (s2_kind)
      KIND_SOLID: begin
        for (int k = 0; k < NUM_CHAN; k++) s3_side_next.c0[k] = schan(stops[s2_solid], k);
      end
      KIND_LERP: begin
        s3_off_next  = s2_pos - spos(stops[s2_lo]);
        s3_span_next = spos(stops[s2_hi]) - spos(stops[s2_lo]);
        for (int k = 0; k < NUM_CHAN; k++) begin
          s3_side_next.c0[k] = schan(stops[s2_lo], k);
          if (schan(stops[s2_hi], k) < schan(stops[s2_lo], k)) begin
            s3_side_next.neg[k] = 1'b1;
            s3_diff_next[k]     = schan(stops[s2_lo], k) - schan(stops[s2_hi], k);
          end else begin
            s3_diff_next[k] = schan(stops[s2_hi], k) - schan(stops[s2_lo], k);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side <= s3_side_next;
      s3_diff <= s3_diff_next;
      s3_off  <= s3_off_next;
      s3_span <= s3_span_next;
    end
  end

  // Stage 4: numerator 2*off*diff + span and divisor 2*span.
  logic                           s4_v;
  side_t                          s4_side;
  logic [NUM_CHAN-1:0][NUM_W-1:0] s4_num;
  logic [DEN_W-1:0]               s4_den;

  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (en) s4_v <= s3_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side <= s3_side;
      s4_den  <= {s3_span, 1'b0};
      for (int k = 0; k < NUM_CHAN; k++) begin
        s4_num[k] <= NUM_W'({PROD_W'(s3_off * s3_diff[k]), 1'b0}) + NUM_W'(s3_span);
      end
    end
  end

  // Rounded quotient per channel.
  logic                            d_v;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] d_q;
  side_t                           d_side;

  gscl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s4_v),
    .num      (s4_num),
    .den      (s4_den),
    .in_side  (s4_side),
    .out_valid(d_v),
    .quot     (d_q),
    .out_side (d_side)
  );

  // Output register: apply the signed step to the lower stop's color, or pass a solid color.
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= d_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= d_side.cvalid;
      for (int k = 0; k < NUM_CHAN; k++) begin
        m_tdata[k*CHAN_W +: CHAN_W] <= d_side.neg[k] ? d_side.c0[k] - d_q[k]
                                                     : d_side.c0[k] + d_q[k];
      end
    end
  end

endmodule

@@ sv/gscl_checker.sv @@
// Port-level checks for the gradient color lookup.
module gscl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // An empty output never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // An undefined color carries zero channels.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 32'd0)
    else $error("nonzero channels on undefined color");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind gradient_stop_color_lookup gscl_checker u_gscl_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

@@ bench/gradient_stop_color_lookup_tb.sv @@
module gradient_stop_color_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gscl_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int PIPE_DEPTH   = 13;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       color_valid;
  } color_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [23:0]          s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [31:0]          m_tdata;
  logic                 m_tuser;
  logic                 cfg_we;
  logic [IDX_W-1:0]     cfg_index;
  logic [STOP_W-1:0]    cfg_data;

  logic [STOP_W-1:0] stops [NUM_STOPS];
  color_t            color_queue [$];
  int                fail_count;
  int                cycle_count;
  int                hold_off;
  bit                bursty;

  gradient_stop_color_lookup DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Rounded channel interpolation, ties away from zero.
  function automatic logic [7:0] blend_channel(logic [7:0] c0, logic [7:0] c1,
                                               logic [16:0] off, logic [16:0] span);
    logic [63:0] diff;
    logic [63:0] q;
    diff = (c1 < c0) ? 64'(c0 - c1) : 64'(c1 - c0);
    q = (2 * 64'(off) * diff + 64'(span)) / (2 * 64'(span));
    return (c1 < c0) ? c0 - q[7:0] : c0 + q[7:0];
  endfunction

  // Expected color at a position for the current stop table.
  function automatic color_t gradient_color(logic [16:0] pos);
    color_t r;
    int cnt, first, lo, hi;
    logic [16:0] p, p0, p1;
    logic [7:0] a, b;
    r = '0;
    cnt = 0; first = -1; lo = -1; hi = -1;
    for (int i = 0; i < NUM_STOPS; i++) begin
      if (stops[i][STOP_VALID_BIT]) begin
        cnt++;
        if (first < 0) first = i;
        p = stops[i][48:32];
        if (p < pos && (lo < 0 || p > stops[lo][48:32])) lo = i;
        if (p > pos && (hi < 0 || p < stops[hi][48:32])) hi = i;
      end
    end
    if (cnt == 0 || (cnt > 1 && lo < 0 && hi < 0)) return r;
    if (cnt == 1 || lo < 0 || hi < 0) begin
      first = (cnt == 1) ? first : ((lo < 0) ? hi : lo);
      {r.red, r.green, r.blue, r.alpha} = stops[first][31:0];
      r.color_valid = 1'b1;
      return r;
    end
    p0 = stops[lo][48:32];
    p1 = stops[hi][48:32];
    for (int k = 0; k < 4; k++) begin
      a = stops[lo][31-8*k -: 8];
      b = stops[hi][31-8*k -: 8];
      case (k)
        0: r.red   = blend_channel(a, b, pos - p0, p1 - p0);
        1: r.green = blend_channel(a, b, pos - p0, p1 - p0);
        2: r.blue  = blend_channel(a, b, pos - p0, p1 - p0);
        default: r.alpha = blend_channel(a, b, pos - p0, p1 - p0);
      endcase
    end
    r.color_valid = 1'b1;
    return r;
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver stall pattern, with an optional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else if (bursty) begin
      m_tready <= (cycle_count % 11 < 7) ? ($urandom_range(0, 3) != 0) : 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expected color.
  always @(posedge clk) begin
    color_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24], m_tuser};
      if (color_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fail_count++;
      end else begin
        want = color_queue.pop_front();
        if (got.red !== want.red)
          $display("%0t: red expected %h actual %h", $time, want.red, got.red);
        if (got.green !== want.green)
          $display("%0t: green expected %h actual %h", $time, want.green, got.green);
        if (got.blue !== want.blue)
          $display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
        if (got.alpha !== want.alpha)
          $display("%0t: alpha expected %h actual %h", $time, want.alpha, got.alpha);
        if (got.color_valid !== want.color_valid)
          $display("%0t: color_valid expected %b actual %b", $time,
                   want.color_valid, got.color_valid);
        if (got !== want) fail_count++;
      end
    end
  end

  // Offer one position until its transfer completes, with bursty gaps.
  // Valid stays high between back-to-back positions and drops in a gap.
  task automatic send_position(logic [16:0] pos);
    if (bursty && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, pos};
    do @(posedge clk); while (!s_tready);
    color_queue.push_back(gradient_color(pos));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (color_queue.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_stop(int idx, logic [STOP_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx[IDX_W-1:0];
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    stops[idx] = value;
    @(posedge clk);
  endtask

  function automatic logic [STOP_W-1:0] make_stop(bit v, logic [16:0] p, logic [31:0] c);
    return {v, p, c};
  endfunction

  function automatic logic [16:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // Default stops, extremes of the position range.
  task automatic test_reset_ramp();
    send_position(17'd0);
    send_position(17'd65536);
    send_position(17'd32768);
    send_position(17'd1);
    send_position(17'd65535);
    send_position(17'h1FFFF);
    wait_drained();
  endtask

  // No valid stop, one valid stop, ties, stops at the query, extreme colors.
  task automatic test_special_cases();
    for (int i = 0; i < NUM_STOPS; i++) write_stop(i, '0);
    send_position(17'd100);
    wait_drained();
    write_stop(5, make_stop(1'b1, 17'd40000, 32'hA5C3_0FF0));
    send_position(17'd0);
    send_position(17'h1FFFF);
    wait_drained();
    write_stop(2, make_stop(1'b1, 17'd40000, 32'h1122_3344));
    send_position(17'd40000);
    send_position(17'd10);
    send_position(17'd50000);
    wait_drained();
    write_stop(0, make_stop(1'b1, 17'd0, 32'hFF00_FF00));
    write_stop(7, make_stop(1'b1, 17'h1FFFF, 32'h00FF_00FF));
    write_stop(3, make_stop(1'b1, 17'd0, 32'h0000_0000));
    send_position(17'd0);
    send_position(17'd20000);
    send_position(17'd60000);
    send_position(17'h1FFFF);
    send_position(17'd3);
    wait_drained();
    write_stop(1, make_stop(1'b1, 17'd2, 32'hFFFF_FFFF));
    write_stop(4, make_stop(1'b1, 17'd4, 32'h0000_0000));
    write_stop(6, make_stop(1'b0, 17'd3, 32'h1234_5678));
    send_position(17'd3);
    send_position(17'd1);
    wait_drained();
  endtask

  // Random stop tables with random positions, bursty on both sides.
  task automatic test_random_ramps();
    bursty = 1'b1;
    for (int phase = 0; phase < 23; phase++) begin
      for (int i = 0; i < NUM_STOPS; i++)
        write_stop(i, make_stop($urandom_range(0, 3) != 0, rand_pos(),
                                32'($urandom())));
      if (phase == 3) hold_off <= 300;
      for (int n = 0; n < 50; n++) send_position(rand_pos());
      wait_drained();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_count = 0;
    cycle_count = 0;
    hold_off = 0;
    bursty = 1'b0;
    for (int i = 0; i < NUM_STOPS; i++) stops[i] = '0;
    stops[0] = STOP0_RESET;
    stops[1] = STOP1_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_ramp();
    test_special_cases();
    test_random_ramps();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
sv/gscl_pkg.sv
sv/gscl_div.sv
sv/gradient_stop_color_lookup.sv
sv/gscl_checker.sv
bench/gradient_stop_color_lookup_tb.sv
